>>> rtl/ipp_pkg.sv
// Shared constants and types for the inverted projection profile block.
package ipp_pkg;

   // Default frame limits
   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   // Word field widths
   localparam int PIXEL_W   = 8;
   localparam int INDEX_W   = 10;
   localparam int VALUE_W   = 11;
   localparam int DIM_REG_W = 11;

   // Arithmetic constants: full-scale pixel and rounding bias for /255
   localparam int PIX_MAX    = 255;
   localparam int ROUND_BIAS = 127;

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      REG_DIRECTION    = 2'd0,
      REG_IMAGE_WIDTH  = 2'd1,
      REG_IMAGE_HEIGHT = 2'd2,
      REG_THRESHOLD    = 2'd3
   } csr_index_type;

   // Direction codes
   localparam logic DIR_ROWS    = 1'b0;
   localparam logic DIR_COLUMNS = 1'b1;

   // Register reset values
   localparam logic [DIM_REG_W-1:0] WIDTH_RESET     = 11'd1024;
   localparam logic [DIM_REG_W-1:0] HEIGHT_RESET    = 11'd1024;
   localparam logic [DIM_REG_W-1:0] THRESHOLD_RESET = 11'd0;

endpackage

>>> rtl/ipp_if.sv
// Valid/ready channel interfaces for pixel words and bin words.
interface ipp_req_if;
   logic                         valid;
   logic                         ready;
   logic [ipp_pkg::PIXEL_W-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface ipp_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ipp_pkg::INDEX_W-1:0]  bin_index;
   logic [ipp_pkg::VALUE_W-1:0]  bin_value;
   logic                         last_bin;

   modport source (output valid, output bin_index, output bin_value, output last_bin,
                   input ready);
   modport sink   (input valid, input bin_index, input bin_value, input last_bin,
                   output ready);
endinterface

>>> rtl/inverted_projection_profile.sv
// Inverted projection profile: row or column sums of a raster frame, mapped to dim - round(sum/255).
// Throughput: one pixel per cycle unless a bin word is held up by output back-pressure.
// The column-sum memory does one read and one write per cycle.
// Stages: accept/memory read, sum + write-back, divide by 255, invert/threshold into output reg.
// Reset (synchronous): clears positions, row sum and stage valids; loads config reset values.
// The column-sum memory is not cleared: row 0 of every frame overwrites each column entry.
module inverted_projection_profile #(
   parameter int MAX_WIDTH  = ipp_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = ipp_pkg::MAX_HEIGHT_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   ipp_req_if.sink                         req_ch,
   ipp_rsp_if.source                       rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ipp_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [ipp_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [ipp_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import ipp_pkg::*;

   localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
   localparam int COL_W   = $clog2(MAX_WIDTH);
   localparam int ROW_W   = $clog2(MAX_HEIGHT);
   localparam int DIM_W   = $clog2(MAX_DIM + 1);
   localparam int CL_W    = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
   localparam int SUM_W   = $clog2(MAX_DIM * PIX_MAX + 1);
   localparam int X_W     = $clog2(MAX_DIM * PIX_MAX + ROUND_BIAS + 1);
   localparam int Q0_W    = X_W - 8;
   localparam int R_W     = ((Q0_W > 8) ? Q0_W : 8) + 1;
   localparam int A_W     = R_W - 8;
   localparam int Q_W     = Q0_W + 1;
   localparam int V_W     = (Q_W > DIM_W) ? Q_W : DIM_W;
   localparam int T_W     = (V_W > VALUE_W) ? V_W : VALUE_W;

   // ---------------------------------------------------------------
   // Config registers
   // ---------------------------------------------------------------
   logic                 dir_ff;
   logic [DIM_REG_W-1:0] width_ff;
   logic [DIM_REG_W-1:0] height_ff;
   logic [DIM_REG_W-1:0] thresh_ff;
   logic                 csr_wr;
   csr_index_type        csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = csr_index_type'(paddr[CSR_ADDR_W-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff    <= DIR_ROWS;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         thresh_ff <= THRESHOLD_RESET;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DIRECTION:    dir_ff    <= pwdata[0];
            REG_IMAGE_WIDTH:  width_ff  <= pwdata[DIM_REG_W-1:0];
            REG_IMAGE_HEIGHT: height_ff <= pwdata[DIM_REG_W-1:0];
            REG_THRESHOLD:    thresh_ff <= pwdata[DIM_REG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DIRECTION:    prdata = CSR_DATA_W'(dir_ff);
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_W'(width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_W'(height_ff);
         REG_THRESHOLD:    prdata = CSR_DATA_W'(thresh_ff);
         default:          prdata = '0;
      endcase
   end

   // Effective dimensions: zero acts as 1, above the maximum acts as the maximum
   logic [CL_W-1:0]  w_cl, h_cl;
   logic [DIM_W-1:0] w_dim, h_dim;

   always_comb begin
      if (width_ff == '0)
         w_cl = CL_W'(1);
      else if (CL_W'(width_ff) > CL_W'(MAX_WIDTH))
         w_cl = CL_W'(MAX_WIDTH);
      else
         w_cl = CL_W'(width_ff);
      if (height_ff == '0)
         h_cl = CL_W'(1);
      else if (CL_W'(height_ff) > CL_W'(MAX_HEIGHT))
         h_cl = CL_W'(MAX_HEIGHT);
      else
         h_cl = CL_W'(height_ff);
   end

   assign w_dim = DIM_W'(w_cl);
   assign h_dim = DIM_W'(h_cl);

   // ---------------------------------------------------------------
   // Pipeline handshake: each stage moves when the next one is free or moving
   // ---------------------------------------------------------------
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   logic s1_emit_ff;
   logic en_out, en3, en2, s1_leave, req_fire, mem_we;

   assign en_out   = !out_valid_ff || rsp_ch.ready;
   assign en3      = !s3_valid_ff || en_out;
   assign en2      = !s2_valid_ff || en3;
   // a pixel that closes no bin drops out after its write-back
   assign s1_leave = s1_valid_ff && (!s1_emit_ff || en2);
   assign req_ch.ready = !s1_valid_ff || s1_leave;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign mem_we   = s1_leave;

   // ---------------------------------------------------------------
   // Accept: raster position, row sum, memory read
   // ---------------------------------------------------------------
   logic [COL_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [SUM_W-1:0] row_sum_ff;
   logic             row_end, last_row;
   logic [SUM_W-1:0] row_sum_acc;

   assign row_end     = DIM_W'(col_ff) >= (w_dim - DIM_W'(1));
   assign last_row    = DIM_W'(row_ff) >= (h_dim - DIM_W'(1));
   assign row_sum_acc = row_sum_ff + SUM_W'(req_ch.pixel);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         row_sum_ff <= '0;
      end else if (req_fire) begin
         if (row_end) begin
            row_sum_ff <= '0;
            col_ff     <= '0;
            row_ff     <= last_row ? '0 : row_ff + ROW_W'(1);
         end else begin
            row_sum_ff <= row_sum_acc;
            col_ff     <= col_ff + COL_W'(1);
         end
      end
   end

   // Stage 1 word
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic [COL_W-1:0]   s1_col_ff;
   logic               s1_first_row_ff;
   logic               s1_dir_ff;
   logic [INDEX_W-1:0] s1_index_ff;
   logic               s1_last_ff;
   logic [SUM_W-1:0]   s1_row_sum_ff;
   logic [SUM_W-1:0]   s1_rd_ff;
   logic               s1_byp_ff;
   logic [SUM_W-1:0]   s1_byp_data_ff;
   logic               s1_emit_in;
   logic [SUM_W-1:0]   col_base, csum;

   // column-sum memory, read at accept, written as stage 1 retires
   logic [SUM_W-1:0] col_mem [MAX_WIDTH];

   assign s1_emit_in = (dir_ff == DIR_ROWS) ? row_end : last_row;

   // read-after-write on the same column (width 1): forward the value being written
   assign col_base = s1_first_row_ff ? '0 : (s1_byp_ff ? s1_byp_data_ff : s1_rd_ff);
   assign csum     = col_base + SUM_W'(s1_pixel_ff);

   always_ff @(posedge clock) begin
      if (mem_we)
         col_mem[s1_col_ff] <= csum;
      if (req_fire)
         s1_rd_ff <= col_mem[col_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_emit_ff  <= 1'b0;
      end else if (req_fire) begin
         s1_valid_ff <= 1'b1;
         s1_emit_ff  <= s1_emit_in;
      end else if (s1_leave) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_pixel_ff     <= req_ch.pixel;
         s1_col_ff       <= col_ff;
         s1_first_row_ff <= (row_ff == '0);
         s1_dir_ff       <= dir_ff;
         s1_index_ff     <= (dir_ff == DIR_ROWS) ? INDEX_W'(row_ff) : INDEX_W'(col_ff);
         s1_last_ff      <= (dir_ff == DIR_ROWS) ? last_row : row_end;
         s1_row_sum_ff   <= row_sum_acc;
         s1_byp_ff       <= mem_we && (s1_col_ff == col_ff);
         s1_byp_data_ff  <= csum;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: pick the bin sum, add rounding bias
   // ---------------------------------------------------------------
   logic [X_W-1:0]     s2_x_ff;
   logic [INDEX_W-1:0] s2_index_ff;
   logic               s2_last_ff;
   logic               s2_dir_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s2_valid_ff <= 1'b0;
      else if (en2)
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_x_ff     <= X_W'((s1_dir_ff == DIR_COLUMNS) ? csum : s1_row_sum_ff)
                        + X_W'(ROUND_BIAS);
         s2_index_ff <= s1_index_ff;
         s2_last_ff  <= s1_last_ff;
         s2_dir_ff   <= s1_dir_ff;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: x / 255 by folding, x = 256*q0 + lo = 255*q0 + (q0 + lo)
   // ---------------------------------------------------------------
   logic [Q0_W-1:0]    q0;
   logic [R_W-1:0]     rem1;
   logic [A_W-1:0]     fold_hi;
   logic [8:0]         rem2;
   logic [Q_W-1:0]     quot;
   logic [Q_W-1:0]     s3_q_ff;
   logic [INDEX_W-1:0] s3_index_ff;
   logic               s3_last_ff;
   logic               s3_dir_ff;

   assign q0      = s2_x_ff[X_W-1:8];
   assign rem1    = R_W'(q0) + R_W'(s2_x_ff[7:0]);
   assign fold_hi = rem1[R_W-1:8];
   assign rem2    = 9'(fold_hi) + 9'(rem1[7:0]);
   assign quot    = Q_W'(q0) + Q_W'(fold_hi) + Q_W'(rem2 >= 9'(PIX_MAX));

   always_ff @(posedge clock) begin
      if (reset)
         s3_valid_ff <= 1'b0;
      else if (en3)
         s3_valid_ff <= s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_q_ff     <= quot;
         s3_index_ff <= s2_index_ff;
         s3_last_ff  <= s2_last_ff;
         s3_dir_ff   <= s2_dir_ff;
      end
   end

   // ---------------------------------------------------------------
   // Output stage: dim - q, saturate at zero, threshold
   // ---------------------------------------------------------------
   logic [V_W-1:0]     dim_v, q_v, inv_v;
   logic [T_W-1:0]     thr_v;
   logic [INDEX_W-1:0] out_index_ff;
   logic [VALUE_W-1:0] out_value_ff;
   logic               out_last_ff;

   assign dim_v = V_W'((s3_dir_ff == DIR_COLUMNS) ? h_dim : w_dim);
   assign q_v   = V_W'(s3_q_ff);
   assign inv_v = (q_v > dim_v) ? '0 : dim_v - q_v;
   assign thr_v = (T_W'(inv_v) < T_W'(thresh_ff)) ? '0 : T_W'(inv_v);

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else if (en_out)
         out_valid_ff <= s3_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         out_index_ff <= s3_index_ff;
         out_value_ff <= VALUE_W'(thr_v);
         out_last_ff  <= s3_last_ff;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.bin_index = out_index_ff;
   assign rsp_ch.bin_value = out_value_ff;
   assign rsp_ch.last_bin  = out_last_ff;

endmodule
